// ===== src/substr_pkg.sv =====
// Shared types, codes and defaults for the substring search core.
package substr_pkg;

	localparam int NEEDLE_MAX_DEF    = 16;
	localparam int POSITION_BITS_DEF = 32;
	localparam int OUT_POS_W         = 32;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

	// input word kinds as carried on s_tuser
	typedef enum logic [1:0] {
		ACT_CLEAR    = 2'd0,
		ACT_APPEND   = 2'd1,
		ACT_HAYSTACK = 2'd2,
		ACT_NOP      = 2'd3
	} action_t;

	// classified work for the back end
	typedef enum logic [2:0] {
		OP_CLEAR   = 3'd0,
		OP_APPEND  = 3'd1,
		OP_RESTART = 3'd2,
		OP_BYTE    = 3'd3,
		OP_END     = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} work_t;

endpackage

// ===== src/substr_front.sv =====
// Front end: accepts input words and classifies them into back-end work.
module substr_front (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                q_full,
	output logic                q_push,
	output substr_pkg::work_t   q_item
);
	import substr_pkg::*;

	action_t act;

	assign act      = action_t'(s_tuser);
	assign s_tready = !q_full;

	always_comb begin
		q_item.data = s_tdata;
		q_item.op   = OP_BYTE;
		q_push      = s_tvalid && !q_full;
		case (act)
			ACT_CLEAR: begin
				q_item.op = OP_CLEAR;
			end
			ACT_APPEND: begin
				// a NUL never joins the needle, but still restarts the search
				q_item.op = (s_tdata == 8'd0) ? OP_RESTART : OP_APPEND;
			end
			ACT_HAYSTACK: begin
				q_item.op = (s_tdata == 8'd0) ? OP_END : OP_BYTE;
			end
			default: begin
				// drop no-op words
				q_push = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/substr_queue.sv =====
// Short work queue between the front end and the back end.
module substr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  substr_pkg::work_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output substr_pkg::work_t head_item
);
	import substr_pkg::*;

	work_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W:0]   wr_ptr_q;
	logic [QPTR_W:0]   rd_ptr_q;
	logic [QPTR_W:0]   fill;

	assign fill       = wr_ptr_q - rd_ptr_q;
	assign full       = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (wr_ptr_q != rd_ptr_q);
	assign head_item  = entry_q[rd_ptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q[QPTR_W-1:0]] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue fill exceeds depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

// ===== src/substr_back.sv =====
// Back end: needle store, haystack window compare, position counter and result register.
module substr_back #(
	parameter int NEEDLE_MAX    = substr_pkg::NEEDLE_MAX_DEF,
	parameter int POSITION_BITS = substr_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  substr_pkg::work_t                  head_item,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [substr_pkg::OUT_POS_W-1:0]   m_tdata,
	output logic                               m_tuser
);
	import substr_pkg::*;

	localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
	localparam int WIN_D = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

	// needle kept newest byte first, so lane k lines up with window lane k
	logic [7:0]               rev_q    [NEEDLE_MAX];
	logic [7:0]               recent_q [WIN_D];
	logic [7:0]               win      [NEEDLE_MAX];
	logic [LEN_W-1:0]         len_q;
	logic                     ovf_q;
	logic [POSITION_BITS-1:0] seen_q;
	logic                     reported_q;

	logic                     m_tvalid_q;
	logic                     found_q;
	logic [OUT_POS_W-1:0]     pos_q;

	logic [NEEDLE_MAX-1:0]    lane_hit;
	logic [LEN_W-1:0]         len_m1;
	logic [POSITION_BITS-1:0] start;
	logic [POSITION_BITS+OUT_POS_W-1:0] start_ext;
	logic                     window_hit;
	logic                     empty_hit;

	logic                     res_valid;
	logic                     res_found;
	logic [OUT_POS_W-1:0]     res_pos;
	logic                     restart;
	logic                     push_win;
	logic                     shift_needle;
	logic [LEN_W-1:0]         len_d;
	logic                     ovf_d;
	logic                     reported_d;

	assign pop      = head_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pos_q;
	assign m_tuser  = found_q;

	always_comb begin
		win[0] = head_item.data;
		for (int k = 1; k < NEEDLE_MAX; k++) begin
			win[k] = recent_q[k-1];
		end
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			lane_hit[k] = (LEN_W'(k) >= len_q) || (rev_q[k] == win[k]);
		end
	end

	assign len_m1     = len_q - LEN_W'(1);
	assign window_hit = (len_q != '0) && (seen_q >= POSITION_BITS'(len_m1)) && (&lane_hit);
	assign start      = seen_q - POSITION_BITS'(len_m1);
	assign start_ext  = {{OUT_POS_W{1'b0}}, start};
	assign empty_hit  = !reported_q && !ovf_q && (len_q == '0);

	always_comb begin
		res_valid    = 1'b0;
		res_found    = 1'b0;
		res_pos      = '0;
		restart      = 1'b0;
		push_win     = 1'b0;
		shift_needle = 1'b0;
		len_d        = len_q;
		ovf_d        = ovf_q;
		reported_d   = reported_q;
		case (head_item.op)
			OP_CLEAR: begin
				len_d   = '0;
				ovf_d   = 1'b0;
				restart = 1'b1;
			end
			OP_APPEND: begin
				if (len_q < LEN_W'(NEEDLE_MAX)) begin
					shift_needle = 1'b1;
					len_d        = len_q + LEN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
				restart = 1'b1;
			end
			OP_RESTART: begin
				restart = 1'b1;
			end
			OP_BYTE: begin
				if (empty_hit) begin
					res_valid  = 1'b1;
					res_found  = 1'b1;
					reported_d = 1'b1;
				end else if (!reported_q && !ovf_q && window_hit) begin
					res_valid  = 1'b1;
					res_found  = 1'b1;
					res_pos    = start_ext[OUT_POS_W-1:0];
					reported_d = 1'b1;
					push_win   = 1'b1;
				end else begin
					push_win = 1'b1;
				end
			end
			OP_END: begin
				if (empty_hit) begin
					res_valid = 1'b1;
					res_found = 1'b1;
				end else if (!reported_q) begin
					res_valid = 1'b1;
				end
				restart = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && shift_needle) begin
			for (int k = 1; k < NEEDLE_MAX; k++) begin
				rev_q[k] <= rev_q[k-1];
			end
			rev_q[0] <= head_item.data;
		end
		if (pop && res_valid) begin
			found_q <= res_found;
			pos_q   <= res_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			ovf_q      <= 1'b0;
			seen_q     <= '0;
			reported_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < WIN_D; k++) begin
				recent_q[k] <= '0;
			end
		end else begin
			if (pop) begin
				len_q <= len_d;
				ovf_q <= ovf_d;
				if (restart) begin
					seen_q     <= '0;
					reported_q <= 1'b0;
					for (int k = 0; k < WIN_D; k++) begin
						recent_q[k] <= '0;
					end
				end else begin
					reported_q <= reported_d;
					if (push_win) begin
						for (int k = 1; k < WIN_D; k++) begin
							recent_q[k] <= recent_q[k-1];
						end
						recent_q[0] <= head_item.data;
						// saturate at all ones
						if (!(&seen_q)) begin
							seen_q <= seen_q + POSITION_BITS'(1);
						end
					end
				end
			end
			if (pop && res_valid) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(NEEDLE_MAX))
		else $error("needle length beyond store depth");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(NEEDLE_MAX)))
		else $error("overflow set with needle store not full");
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !found_q) |-> (pos_q == '0))
		else $error("not-found result with nonzero position");
	a_hit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && res_valid && (head_item.op == OP_BYTE)) |=> reported_q)
		else $error("match on a haystack byte not marked as reported");
`endif

endmodule

// ===== src/substring_search_core.sv =====
// Path: a word that causes a result is held in the work queue, then its result is registered
// in the result register; words queued ahead of it are taken from the queue first.
// Throughput: one input word per cycle while the queue has room, set by the window compare in
// the back end; a stalled result register holds the back end while the four-word queue fills.
// Reset (arst_n, asynchronous): clears needle length, overflow, window, position counter,
// queue pointers and output valid; needle bytes are undefined until appended.
module substring_search_core #(
	parameter int NEEDLE_MAX    = substr_pkg::NEEDLE_MAX_DEF,
	parameter int POSITION_BITS = substr_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  logic [1:0]                       s_tuser,   // [1:0] action
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [substr_pkg::OUT_POS_W-1:0] m_tdata,   // [31:0] match_position
	output logic                             m_tuser    // [0] found
);
	import substr_pkg::*;

	logic  q_full;
	logic  q_push;
	work_t q_in;
	logic  q_pop;
	logic  q_valid;
	work_t q_head;

	substr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	substr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head)
	);

	substr_back #(
		.NEEDLE_MAX    (NEEDLE_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
